FILE: rtl/crf_pkg.sv
// Shared types, codes and constants for the clipped rectangle strip fill.
// No dependencies; used by every module under rtl/.
package crf_pkg;

  // default geometry
  localparam int SCREEN_W_DEF     = 240;
  localparam int SCREEN_H_DEF     = 240;
  localparam int STRIP_PIXELS_DEF = 4096;

  // signed coordinate width: 16-bit inputs plus headroom for x + w
  localparam int CW         = 18;
  // store address width: row * stride + column stays below 2**17
  localparam int ADDR_W     = 17;
  localparam int REG_ADDR_W = 5;

  typedef logic signed [CW-1:0] coord_t;

  // command codes
  localparam logic CMD_FILL = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // register indexes
  localparam logic [2:0] REG_CLIP_X  = 3'd0;
  localparam logic [2:0] REG_CLIP_Y  = 3'd1;
  localparam logic [2:0] REG_CLIP_W  = 3'd2;
  localparam logic [2:0] REG_CLIP_H  = 3'd3;
  localparam logic [2:0] REG_STRIP_X = 3'd4;
  localparam logic [2:0] REG_STRIP_Y = 3'd5;
  localparam logic [2:0] REG_STRIP_W = 3'd6;
  localparam logic [2:0] REG_STRIP_H = 3'd7;

  // register reset values
  localparam logic [7:0] CLIP_X_RST  = 8'd0;
  localparam logic [7:0] CLIP_Y_RST  = 8'd0;
  localparam logic [7:0] CLIP_W_RST  = 8'd240;
  localparam logic [7:0] CLIP_H_RST  = 8'd240;
  localparam logic [7:0] STRIP_X_RST = 8'd0;
  localparam logic [7:0] STRIP_Y_RST = 8'd0;
  localparam logic [7:0] STRIP_W_RST = 8'd240;
  localparam logic [7:0] STRIP_H_RST = 8'd16;

  typedef struct packed {
    logic [7:0] clip_x;
    logic [7:0] clip_y;
    logic [7:0] clip_w;
    logic [7:0] clip_h;
    logic [7:0] strip_x;
    logic [7:0] strip_y;
    logic [7:0] strip_w;
    logic [7:0] strip_h;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCREEN,
    S_WIN,
    S_STRIP,
    S_SIZE,
    S_BASE,
    S_FILL,
    S_DONE
  } state_t;

  typedef enum logic {
    WIN_CLIP,
    WIN_STRIP
  } win_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;
    logic     screen;
    logic     win_en;
    win_sel_t win_sel;
    logic     size;
    logic     base;
    logic     fill;
    logic     out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cmd;
    logic ok;
    logic fill_last;
  } dp_sts_t;

endpackage

FILE: rtl/crf_regs.sv
// APB-style register file holding the clip and strip windows.
// Depends on crf_pkg.
module crf_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crf_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output crf_pkg::cfg_t                  cfg
);
  import crf_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;
  logic [7:0] wval;
  logic [7:0] rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign wval   = pwdata[7:0];
  assign cfg    = cfg_r;
  assign prdata = {24'd0, rval};

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CLIP_X:  cfg_nxt.clip_x  = wval;
        REG_CLIP_Y:  cfg_nxt.clip_y  = wval;
        REG_CLIP_W:  cfg_nxt.clip_w  = wval;
        REG_CLIP_H:  cfg_nxt.clip_h  = wval;
        REG_STRIP_X: cfg_nxt.strip_x = wval;
        REG_STRIP_Y: cfg_nxt.strip_y = wval;
        REG_STRIP_W: cfg_nxt.strip_w = wval;
        REG_STRIP_H: cfg_nxt.strip_h = wval;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CLIP_X:  rval = cfg_r.clip_x;
      REG_CLIP_Y:  rval = cfg_r.clip_y;
      REG_CLIP_W:  rval = cfg_r.clip_w;
      REG_CLIP_H:  rval = cfg_r.clip_h;
      REG_STRIP_X: rval = cfg_r.strip_x;
      REG_STRIP_Y: rval = cfg_r.strip_y;
      REG_STRIP_W: rval = cfg_r.strip_w;
      REG_STRIP_H: rval = cfg_r.strip_h;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_x  <= CLIP_X_RST;
      cfg_r.clip_y  <= CLIP_Y_RST;
      cfg_r.clip_w  <= CLIP_W_RST;
      cfg_r.clip_h  <= CLIP_H_RST;
      cfg_r.strip_x <= STRIP_X_RST;
      cfg_r.strip_y <= STRIP_Y_RST;
      cfg_r.strip_w <= STRIP_W_RST;
      cfg_r.strip_h <= STRIP_H_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/crf_ctrl.sv
// Command sequencer: clip steps, fill scan, result handoff.
// Depends on crf_pkg.
module crf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  crf_pkg::dp_sts_t sts,
  output crf_pkg::dp_cmd_t dp_cmd,
  output crf_pkg::state_t  state
);
  import crf_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign state     = state_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_SCREEN;
        end
      end
      S_SCREEN: begin
        dp_cmd.screen = 1'b1;
        state_nxt     = S_WIN;
      end
      S_WIN: begin
        dp_cmd.win_en  = 1'b1;
        dp_cmd.win_sel = WIN_CLIP;
        state_nxt      = S_STRIP;
      end
      S_STRIP: begin
        dp_cmd.win_en  = 1'b1;
        dp_cmd.win_sel = WIN_STRIP;
        state_nxt      = S_SIZE;
      end
      S_SIZE: begin
        dp_cmd.size = 1'b1;
        state_nxt   = (sts.cmd == CMD_FILL) ? S_BASE : S_DONE;
      end
      S_BASE: begin
        dp_cmd.base = 1'b1;
        state_nxt   = sts.ok ? S_FILL : S_DONE;
      end
      S_FILL: begin
        dp_cmd.fill = 1'b1;
        if (sts.fill_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          dp_cmd.out_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.out_load)  out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
  end

endmodule

FILE: rtl/crf_dp.sv
// Datapath: command capture, shared window clipper, fill address walk,
// pixel store and result register. Depends on crf_pkg.
module crf_dp #(
  parameter int SCREEN_W     = crf_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H     = crf_pkg::SCREEN_H_DEF,
  parameter int STRIP_PIXELS = crf_pkg::STRIP_PIXELS_DEF
) (
  input  logic               clk,
  input  crf_pkg::cfg_t      cfg,
  input  crf_pkg::dp_cmd_t   dp_cmd,
  output crf_pkg::dp_sts_t   sts,
  input  logic               in_cmd,
  input  logic signed [15:0] in_rect_x,
  input  logic signed [15:0] in_rect_y,
  input  logic signed [15:0] in_rect_w,
  input  logic signed [15:0] in_rect_h,
  input  logic [15:0]        in_fill_color,
  input  logic [11:0]        in_pixel_index,
  output logic               out_drawn,
  output logic [7:0]         out_drawn_x,
  output logic [7:0]         out_drawn_y,
  output logic [7:0]         out_drawn_w,
  output logic [7:0]         out_drawn_h,
  output logic [15:0]        out_read_pixel
);
  import crf_pkg::*;

  localparam int                AW      = $clog2(STRIP_PIXELS);
  localparam coord_t            SW_C    = coord_t'(SCREEN_W);
  localparam coord_t            SH_C    = coord_t'(SCREEN_H);
  localparam logic [ADDR_W-1:0] DEPTH_C = ADDR_W'(STRIP_PIXELS);

  // captured command; x1/y1 hold w/h until the screen step
  logic              cmd_r;
  logic [15:0]       color_r;
  logic [11:0]       pidx_r;
  coord_t            x0_r, y0_r, x1_r, y1_r;
  logic              ok_r;
  logic [7:0]        w_r, h_r;

  // fill walk
  logic [ADDR_W-1:0] row_start_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        col_r, row_r;

  // store
  logic [15:0]       mem [STRIP_PIXELS];
  logic [15:0]       rd_q_r;
  logic              rd_hit_r;

  // result register
  logic              res_drawn_r;
  logic [7:0]        res_x_r, res_y_r, res_w_r, res_h_r;
  logic [15:0]       res_pix_r;

  // screen step
  coord_t            sx_sum, sy_sum;
  logic              scr_ok;
  coord_t            scr_x0, scr_y0, scr_x1, scr_y1;

  // window step
  logic [7:0]        wx8, wy8, ww8, wh8;
  coord_t            wx, wy, wr, wb;
  logic              win_hit;
  coord_t            win_x0, win_y0, win_x1, win_y1;

  // size step
  coord_t            dw, dh;
  logic              size_ok;
  logic [ADDR_W-1:0] pidx_ext;
  logic [AW-1:0]     rd_addr;

  // base and fill
  logic [7:0]        rel_x, rel_y;
  logic [15:0]       prod;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] next_row;
  logic              col_end, row_end;
  logic              we;

  assign sx_sum = x0_r + x1_r;
  assign sy_sum = y0_r + y1_r;
  assign scr_ok = !x1_r[CW-1] && (x1_r != '0) && !y1_r[CW-1] && (y1_r != '0)
                  && (x0_r < SW_C) && (y0_r < SH_C);
  assign scr_x0 = x0_r[CW-1] ? coord_t'(0) : x0_r;
  assign scr_y0 = y0_r[CW-1] ? coord_t'(0) : y0_r;
  assign scr_x1 = (sx_sum > SW_C) ? SW_C : sx_sum;
  assign scr_y1 = (sy_sum > SH_C) ? SH_C : sy_sum;

  always_comb begin
    case (dp_cmd.win_sel)
      WIN_CLIP: begin
        wx8 = cfg.clip_x;  wy8 = cfg.clip_y;  ww8 = cfg.clip_w;  wh8 = cfg.clip_h;
      end
      default: begin
        wx8 = cfg.strip_x; wy8 = cfg.strip_y; ww8 = cfg.strip_w; wh8 = cfg.strip_h;
      end
    endcase
  end

  assign wx = $signed({{(CW-8){1'b0}}, wx8});
  assign wy = $signed({{(CW-8){1'b0}}, wy8});
  assign wr = $signed({{(CW-9){1'b0}}, 9'(wx8) + 9'(ww8)});
  assign wb = $signed({{(CW-9){1'b0}}, 9'(wy8) + 9'(wh8)});

  assign win_hit = !((x1_r <= wx) || (y1_r <= wy) || (x0_r >= wr) || (y0_r >= wb));
  assign win_x0  = (x0_r < wx) ? wx : x0_r;
  assign win_y0  = (y0_r < wy) ? wy : y0_r;
  assign win_x1  = (x1_r > wr) ? wr : x1_r;
  assign win_y1  = (y1_r > wb) ? wb : y1_r;

  assign dw      = x1_r - x0_r;
  assign dh      = y1_r - y0_r;
  assign size_ok = ok_r && !dw[CW-1] && (dw != '0) && !dh[CW-1] && (dh != '0);

  assign pidx_ext = ADDR_W'(pidx_r);
  assign rd_addr  = pidx_ext[AW-1:0];

  // offsets inside the strip are below strip_w / strip_h, so 8 bits hold them
  assign rel_x     = x0_r[7:0] - cfg.strip_x;
  assign rel_y     = y0_r[7:0] - cfg.strip_y;
  assign prod      = rel_y * cfg.strip_w;
  assign base_addr = ADDR_W'(prod) + ADDR_W'(rel_x);
  assign next_row  = row_start_r + ADDR_W'(cfg.strip_w);

  assign col_end = (col_r == w_r - 8'd1);
  assign row_end = (row_r == h_r - 8'd1);
  assign we      = dp_cmd.fill && (addr_r < DEPTH_C);

  assign sts.cmd       = cmd_r;
  assign sts.ok        = ok_r;
  assign sts.fill_last = col_end && row_end;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r   <= in_cmd;
      color_r <= in_fill_color;
      pidx_r  <= in_pixel_index;
      x0_r    <= {{(CW-16){in_rect_x[15]}}, in_rect_x};
      y0_r    <= {{(CW-16){in_rect_y[15]}}, in_rect_y};
      x1_r    <= {{(CW-16){in_rect_w[15]}}, in_rect_w};
      y1_r    <= {{(CW-16){in_rect_h[15]}}, in_rect_h};
    end
    if (dp_cmd.screen) begin
      ok_r <= scr_ok;
      x0_r <= scr_x0;
      y0_r <= scr_y0;
      x1_r <= scr_x1;
      y1_r <= scr_y1;
    end
    if (dp_cmd.win_en) begin
      ok_r <= ok_r && win_hit;
      x0_r <= win_x0;
      y0_r <= win_y0;
      x1_r <= win_x1;
      y1_r <= win_y1;
    end
    if (dp_cmd.size) begin
      ok_r     <= size_ok;
      w_r      <= dw[7:0];
      h_r      <= dh[7:0];
      rd_hit_r <= pidx_ext < DEPTH_C;
    end
    if (dp_cmd.base) begin
      row_start_r <= base_addr;
      addr_r      <= base_addr;
      col_r       <= 8'd0;
      row_r       <= 8'd0;
    end
    if (dp_cmd.fill) begin
      if (col_end) begin
        row_start_r <= next_row;
        addr_r      <= next_row;
        col_r       <= 8'd0;
        row_r       <= row_r + 8'd1;
      end else begin
        addr_r <= addr_r + ADDR_W'(1);
        col_r  <= col_r + 8'd1;
      end
    end
    if (dp_cmd.out_load) begin
      res_drawn_r <= ok_r;
      res_x_r     <= ok_r ? x0_r[7:0] : 8'd0;
      res_y_r     <= ok_r ? y0_r[7:0] : 8'd0;
      res_w_r     <= ok_r ? w_r : 8'd0;
      res_h_r     <= ok_r ? h_r : 8'd0;
      res_pix_r   <= ((cmd_r == CMD_READ) && rd_hit_r) ? rd_q_r : 16'd0;
    end
  end

  // pixel store: one write port for the fill walk, one registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr_r[AW-1:0]] <= color_r;
    if (dp_cmd.size) rd_q_r <= mem[rd_addr];
  end

  assign out_drawn      = res_drawn_r;
  assign out_drawn_x    = res_x_r;
  assign out_drawn_y    = res_y_r;
  assign out_drawn_w    = res_w_r;
  assign out_drawn_h    = res_h_r;
  assign out_read_pixel = res_pix_r;

endmodule

FILE: rtl/clipped_rect_fill_strip.sv
// Top level of the clipped rectangle strip fill: registers, sequencer,
// datapath with pixel store. Depends on crf_pkg, crf_regs, crf_ctrl, crf_dp.
//
//   port group   dir  handshake              word
//   in_*         in   in_valid / in_ready    cmd, rect_x/y/w/h, fill_color, pixel_index
//   out_*        out  out_valid / out_ready  drawn, drawn_x/y/w/h, read_pixel
//   APB          in   psel & penable         8 window registers at 4*i, 8 bits used
//
// Steps: every word passes the screen, clip, strip and size steps to the
// result register; a fill adds the base step and, if not empty, a scan of
// w*h pixels, one pixel store write per cycle set by the single store write
// port. The clipper is shared by the clip and strip windows, one step each.
// in_ready is high whenever the sequencer is idle, even while a finished
// result waits in the output register; a new result only waits if the
// previous one is still untaken. Reset (rst_n low, synchronous) restores
// register defaults and idles the sequencer; the pixel store is not cleared.
module clipped_rect_fill_strip #(
  parameter int SCREEN_W     = crf_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H     = crf_pkg::SCREEN_H_DEF,
  parameter int STRIP_PIXELS = crf_pkg::STRIP_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic signed [15:0]             in_rect_x,
  input  logic signed [15:0]             in_rect_y,
  input  logic signed [15:0]             in_rect_w,
  input  logic signed [15:0]             in_rect_h,
  input  logic [15:0]                    in_fill_color,
  input  logic [11:0]                    in_pixel_index,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_drawn,
  output logic [7:0]                     out_drawn_x,
  output logic [7:0]                     out_drawn_y,
  output logic [7:0]                     out_drawn_w,
  output logic [7:0]                     out_drawn_h,
  output logic [15:0]                    out_read_pixel,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crf_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import crf_pkg::*;

  cfg_t    cfg;
  dp_cmd_t dp_cmd;
  dp_sts_t sts;
  state_t  state;

  crf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .dp_cmd    (dp_cmd),
    .state     (state)
  );

  crf_dp #(
    .SCREEN_W     (SCREEN_W),
    .SCREEN_H     (SCREEN_H),
    .STRIP_PIXELS (STRIP_PIXELS)
  ) u_dp (
    .clk            (clk),
    .cfg            (cfg),
    .dp_cmd         (dp_cmd),
    .sts            (sts),
    .in_cmd         (in_cmd),
    .in_rect_x      (in_rect_x),
    .in_rect_y      (in_rect_y),
    .in_rect_w      (in_rect_w),
    .in_rect_h      (in_rect_h),
    .in_fill_color  (in_fill_color),
    .in_pixel_index (in_pixel_index),
    .out_drawn      (out_drawn),
    .out_drawn_x    (out_drawn_x),
    .out_drawn_y    (out_drawn_y),
    .out_drawn_w    (out_drawn_w),
    .out_drawn_h    (out_drawn_h),
    .out_read_pixel (out_read_pixel)
  );

`ifndef ASSERT_OFF
  // one command at a time: taking a word closes the input until done
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a command is in flight");

  // an empty result reports an all-zero rectangle
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_drawn) |-> (out_drawn_x == 8'd0 && out_drawn_y == 8'd0
                                   && out_drawn_w == 8'd0 && out_drawn_h == 8'd0))
    else $error("empty result with nonzero rectangle");

  // a drawn rectangle is non-empty and fits inside the strip
  a_drawn_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drawn) |-> (out_drawn_w != 8'd0 && out_drawn_h != 8'd0
                                  && out_drawn_w <= cfg.strip_w
                                  && out_drawn_h <= cfg.strip_h))
    else $error("drawn rectangle empty or outside strip");

  // fill scan only runs on a command that survived clipping
  a_fill_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_FILL) |-> (sts.ok && sts.cmd == CMD_FILL))
    else $error("fill scan on empty or read command");
`endif

endmodule

FILE: bench/clipped_rect_fill_strip_test.sv
// Self-checking bench for clipped_rect_fill_strip: directed and random fill/read words,
// APB window setup, random idling on both channels. Depends on crf_pkg and the RTL top.
module clipped_rect_fill_strip_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crf_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int SCR_W      = SCREEN_W_DEF;
  localparam int SCR_H      = SCREEN_H_DEF;
  localparam int STORE_SIZE = STRIP_PIXELS_DEF;
  localparam int HOLD_LEN   = 400;   // long receiver hold-off, in cycles
  localparam int MAX_REPORT = 10;

  // one command word as offered on in_*
  typedef struct {
    logic               cmd;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic [15:0]        fill_color;
    logic [11:0]        pixel_index;
  } fill_cmd_t;

  // one result word as seen on out_*
  typedef struct {
    logic        drawn;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [15:0] pixel;
  } fill_result_t;

  // ------------------------------------------------------------------
  // Scoreboard: shadow copy of the window registers and the pixel store,
  // predicts the result word of every accepted command and checks results
  // in order against it.
  // ------------------------------------------------------------------
  class fill_scoreboard;
    logic [7:0]   clip_x  = CLIP_X_RST;
    logic [7:0]   clip_y  = CLIP_Y_RST;
    logic [7:0]   clip_w  = CLIP_W_RST;
    logic [7:0]   clip_h  = CLIP_H_RST;
    logic [7:0]   strip_x = STRIP_X_RST;
    logic [7:0]   strip_y = STRIP_Y_RST;
    logic [7:0]   strip_w = STRIP_W_RST;
    logic [7:0]   strip_h = STRIP_H_RST;
    logic [15:0]  pixels  [STORE_SIZE];
    bit           written [STORE_SIZE];
    fill_result_t expected_results[$];
    int           fail_count = 0;

    function void log_failure(string what);
      fail_count++;
      if (fail_count <= MAX_REPORT) $display("%t: %s", $realtime, what);
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_CLIP_X:  clip_x  = val;
        REG_CLIP_Y:  clip_y  = val;
        REG_CLIP_W:  clip_w  = val;
        REG_CLIP_H:  clip_h  = val;
        REG_STRIP_X: strip_x = val;
        REG_STRIP_Y: strip_y = val;
        REG_STRIP_W: strip_w = val;
        REG_STRIP_H: strip_h = val;
        default: ;
      endcase
    endfunction

    // intersect [x0,x1) x [y0,y1) with a window; 0 when nothing is left
    function bit clip_window(inout int x0, inout int y0, inout int x1, inout int y1,
                             input int wx, input int wy, input int ww, input int wh);
      if (x1 <= wx || y1 <= wy || x0 >= wx + ww || y0 >= wy + wh) return 1'b0;
      if (x0 < wx) x0 = wx;
      if (y0 < wy) y0 = wy;
      if (x1 > wx + ww) x1 = wx + ww;
      if (y1 > wy + wh) y1 = wy + wh;
      return 1'b1;
    endfunction

    function void note_command(fill_cmd_t c);
      int           x, y, w, h, x1, y1, rx, ry, addr, row, col;
      bit           ok;
      fill_result_t r;
      x  = int'(c.rect_x);
      y  = int'(c.rect_y);
      w  = int'(c.rect_w);
      h  = int'(c.rect_h);
      x1 = 0;
      y1 = 0;
      ok = !(w <= 0 || h <= 0 || x >= SCR_W || y >= SCR_H);
      if (ok) begin
        // screen first, then clip window, then strip window
        if (x < 0) begin
          w += x;
          x = 0;
        end
        if (y < 0) begin
          h += y;
          y = 0;
        end
        if (x + w > SCR_W) w = SCR_W - x;
        if (y + h > SCR_H) h = SCR_H - y;
        x1 = x + w;
        y1 = y + h;
        ok = clip_window(x, y, x1, y1, int'(clip_x), int'(clip_y),
                         int'(clip_w), int'(clip_h));
        if (ok) ok = clip_window(x, y, x1, y1, int'(strip_x), int'(strip_y),
                                 int'(strip_w), int'(strip_h));
        if (ok) begin
          w  = x1 - x;
          h  = y1 - y;
          ok = (w > 0) && (h > 0);
        end
      end
      if (!ok) begin
        x = 0;
        y = 0;
        w = 0;
        h = 0;
      end
      r.drawn = ok;
      r.x     = x[7:0];
      r.y     = y[7:0];
      r.w     = w[7:0];
      r.h     = h[7:0];
      r.pixel = '0;
      if (c.cmd == CMD_FILL) begin
        if (ok) begin
          // store is row-major from the strip origin; addresses past the end drop
          rx = x - int'(strip_x);
          ry = y - int'(strip_y);
          for (row = 0; row < h; row++) begin
            for (col = 0; col < w; col++) begin
              addr = (ry + row) * int'(strip_w) + rx + col;
              if (addr < STORE_SIZE) begin
                pixels[addr]  = c.fill_color;
                written[addr] = 1'b1;
              end
            end
          end
        end
      end else if (int'(c.pixel_index) < STORE_SIZE) begin
        r.pixel = pixels[c.pixel_index];
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(fill_result_t got);
      fill_result_t want;
      if (expected_results.size() == 0) begin
        log_failure($sformatf("unexpected result drawn=%0d x=%0d y=%0d w=%0d h=%0d px=%h",
                              got.drawn, got.x, got.y, got.w, got.h, got.pixel));
        return;
      end
      want = expected_results.pop_front();
      if (got.drawn !== want.drawn || got.x !== want.x || got.y !== want.y ||
          got.w !== want.w || got.h !== want.h || got.pixel !== want.pixel)
        log_failure($sformatf({"mismatch: expected drawn=%0d x=%0d y=%0d w=%0d h=%0d px=%h,",
                               " got drawn=%0d x=%0d y=%0d w=%0d h=%0d px=%h"},
                              want.drawn, want.x, want.y, want.w, want.h, want.pixel,
                              got.drawn, got.x, got.y, got.w, got.h, got.pixel));
    endfunction
  endclass

  // ------------------------------------------------------------------
  // Clock, reset and DUT-facing signals (all known from time zero)
  // ------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic               in_cmd         = CMD_FILL;
  logic signed [15:0] in_rect_x      = '0;
  logic signed [15:0] in_rect_y      = '0;
  logic signed [15:0] in_rect_w      = '0;
  logic signed [15:0] in_rect_h      = '0;
  logic [15:0]        in_fill_color  = '0;
  logic [11:0]        in_pixel_index = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_drawn;
  logic [7:0]  out_drawn_x;
  logic [7:0]  out_drawn_y;
  logic [7:0]  out_drawn_w;
  logic [7:0]  out_drawn_h;
  logic [15:0] out_read_pixel;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [REG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // idling knobs, percent per cycle; written only by the stimulus process
  int gap_pct   = 0;
  int stall_pct = 0;
  // each bump asks the receiver for one long hold-off
  int hold_reqs = 0;

  fill_scoreboard sb = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  clipped_rect_fill_strip uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_rect_x      (in_rect_x),
    .in_rect_y      (in_rect_y),
    .in_rect_w      (in_rect_w),
    .in_rect_h      (in_rect_h),
    .in_fill_color  (in_fill_color),
    .in_pixel_index (in_pixel_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_drawn      (out_drawn),
    .out_drawn_x    (out_drawn_x),
    .out_drawn_y    (out_drawn_y),
    .out_drawn_w    (out_drawn_w),
    .out_drawn_h    (out_drawn_h),
    .out_read_pixel (out_read_pixel),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // ------------------------------------------------------------------
  // Result side: check every word taken, then pick out_ready for the next
  // edge. Outputs are read right after the edge, before the DUT's updates
  // land, so they are the values the handshake saw.
  // ------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    fill_result_t got;
    if (out_valid === 1'b1 && out_ready) begin
      got.drawn = out_drawn;
      got.x     = out_drawn_x;
      got.y     = out_drawn_y;
      got.w     = out_drawn_w;
      got.h     = out_drawn_h;
      got.pixel = out_read_pixel;
      sb.check_result(got);
    end
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // offer one word, keep valid high after acceptance (caller lowers it)
  task automatic send_command(input fill_cmd_t c);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= c.cmd;
    in_rect_x      <= c.rect_x;
    in_rect_y      <= c.rect_y;
    in_rect_w      <= c.rect_w;
    in_rect_h      <= c.rect_h;
    in_fill_color  <= c.fill_color;
    in_pixel_index <= c.pixel_index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(c);
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
  endtask

  // APB write: setup cycle, access cycle, idle cycle
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // new clip and strip windows, only with the block idle
  task automatic apply_window(input int cx, input int cy, input int cw, input int ch,
                              input int sx, input int sy, input int sw, input int sh);
    drain_results();
    write_reg(REG_CLIP_X, 8'(cx));
    write_reg(REG_CLIP_Y, 8'(cy));
    write_reg(REG_CLIP_W, 8'(cw));
    write_reg(REG_CLIP_H, 8'(ch));
    write_reg(REG_STRIP_X, 8'(sx));
    write_reg(REG_STRIP_Y, 8'(sy));
    write_reg(REG_STRIP_W, 8'(sw));
    write_reg(REG_STRIP_H, 8'(sh));
  endtask

  function automatic fill_cmd_t make_cmd(logic cmd, int x, int y, int w, int h,
                                         int color, int index);
    fill_cmd_t c;
    c.cmd         = cmd;
    c.rect_x      = 16'(x);
    c.rect_y      = 16'(y);
    c.rect_w      = 16'(w);
    c.rect_h      = 16'(h);
    c.fill_color  = 16'(color);
    c.pixel_index = 12'(index);
    return c;
  endfunction

  // coordinates around the screen border and the 16-bit limits
  function automatic int extreme_coord();
    case ($urandom_range(8))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 239;
      6: return 240;
      7: return 241;
      default: return 32767;
    endcase
  endfunction

  // Mostly small rectangles aimed at the strip window so fills land in the
  // store; some fully random words and some border values. Reads only hit
  // entries already written.
  function automatic fill_cmd_t random_command();
    fill_cmd_t c;
    int        pick;
    c.cmd         = ($urandom_range(99) < 20) ? CMD_READ : CMD_FILL;
    c.fill_color  = 16'($urandom);
    c.pixel_index = 12'($urandom);
    if (!sb.written[c.pixel_index]) c.pixel_index = '0;
    pick = $urandom_range(99);
    if (pick < 70) begin
      c.rect_x = 16'(int'(sb.strip_x) - 8 + int'($urandom_range(int'(sb.strip_w) + 16)));
      c.rect_y = 16'(int'(sb.strip_y) - 8 + int'($urandom_range(int'(sb.strip_h) + 16)));
      c.rect_w = 16'(($urandom_range(9) == 0) ? int'($urandom_range(64))
                                              : int'($urandom_range(20)) - 2);
      c.rect_h = 16'(($urandom_range(9) == 0) ? int'($urandom_range(64))
                                              : int'($urandom_range(20)) - 2);
    end else if (pick < 85) begin
      c.rect_x = 16'($urandom);
      c.rect_y = 16'($urandom);
      c.rect_w = 16'($urandom);
      c.rect_h = 16'($urandom);
    end else begin
      c.rect_x = 16'(extreme_coord());
      c.rect_y = 16'(extreme_coord());
      c.rect_w = 16'(extreme_coord());
      c.rect_h = 16'(extreme_coord());
    end
    return c;
  endfunction

  // one window setting plus a batch of random words; optionally a long
  // receiver hold-off or a full drain halfway through
  task automatic run_phase(input int cx, input int cy, input int cw, input int ch,
                           input int sx, input int sy, input int sw, input int sh,
                           input int items, input int gap, input int stall,
                           input bit hold_mid, input bit drain_mid);
    apply_window(cx, cy, cw, ch, sx, sy, sw, sh);
    gap_pct   = gap;
    stall_pct = stall;
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) begin
        if (hold_mid) hold_reqs++;
        if (drain_mid) drain_results();
      end
      send_command(random_command());
    end
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at reset windows (full clip, strip 240x16 at the origin).
    // The first fill covers the whole strip so every later read is defined.
    send_command(make_cmd(CMD_FILL, 0, 0, 240, 240, 16'hFFFF, 0));
    send_command(make_cmd(CMD_READ, 0, 0, 1, 1, 0, 0));
    send_command(make_cmd(CMD_READ, -32768, -32768, 32767, 32767, 16'hFFFF, 3839));
    // empty cases: negative span, off screen, zero and negative sizes
    send_command(make_cmd(CMD_FILL, -32768, -32768, 32767, 32767, 16'h1234, 0));
    send_command(make_cmd(CMD_FILL, 32767, 0, 10, 10, 16'h1234, 0));
    send_command(make_cmd(CMD_FILL, 0, 32767, 10, 10, 16'h1234, 0));
    send_command(make_cmd(CMD_FILL, 5, 5, 0, 10, 16'h1234, 0));
    send_command(make_cmd(CMD_FILL, 5, 5, 10, -32768, 16'h1234, 0));
    send_command(make_cmd(CMD_FILL, 5, 5, -1, -1, 16'h1234, 0));
    // clipped at top-left, at the right screen edge, and a single pixel
    send_command(make_cmd(CMD_FILL, -5, -3, 10, 8, 16'h0000, 0));
    send_command(make_cmd(CMD_FILL, 235, 10, 100, 100, 16'h8001, 0));
    send_command(make_cmd(CMD_FILL, 239, 15, 1, 1, 16'h7FFE, 0));
    // below the strip: clips to nothing
    send_command(make_cmd(CMD_FILL, 0, 16, 10, 10, 16'h1234, 0));
    // reads still report the clipped rectangle
    send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 3839));
    send_command(make_cmd(CMD_READ, 235, 10, 100, 100, 0, 0));
    send_command(make_cmd(CMD_READ, 32767, 32767, 32767, 32767, 16'hFFFF, 2400));

    // tall strip: rows past the store end are dropped, top entries filled
    apply_window(0, 0, 240, 240, 0, 0, 240, 240);
    send_command(make_cmd(CMD_FILL, 0, 16, 240, 2, 16'hA5A5, 0));
    send_command(make_cmd(CMD_READ, 32767, -1, 1, 32767, 16'h5A5A, 4095));
    send_command(make_cmd(CMD_READ, -1, 0, 32767, 1, 0, 3840));
    send_command(make_cmd(CMD_FILL, 0, 0, 1, 1, 16'h5A5A, 0));

    // random phases: window settings x idling mode
    run_phase(10, 20, 100, 60, 0, 16, 64, 32, 90, 0, 0, 1'b1, 1'b0);
    run_phase(0, 0, 240, 240, 200, 220, 40, 20, 90, 64, 0, 1'b0, 1'b1);
    // stride 255: most of the strip maps past the store
    run_phase(0, 0, 240, 40, 0, 0, 255, 255, 70, 0, 64, 1'b0, 1'b0);
    // all registers at their top value: windows off screen
    run_phase(255, 255, 255, 255, 255, 255, 255, 255, 15, 14, 14, 1'b0, 1'b0);
    // zero-sized windows
    run_phase(0, 0, 0, 240, 0, 0, 240, 16, 10, 0, 0, 1'b0, 1'b0);
    run_phase(0, 0, 240, 0, 0, 0, 0, 0, 10, 64, 64, 1'b0, 1'b0);
    for (int k = 0; k < 3; k++) begin
      run_phase($urandom_range(200), $urandom_range(200),
                $urandom_range(1, 240), $urandom_range(1, 240),
                $urandom_range(220), $urandom_range(230),
                $urandom_range(1, 64), $urandom_range(1, 64), 60,
                (k == 1) ? 64 : ((k == 0) ? 14 : 0),
                (k == 2) ? 64 : ((k == 0) ? 14 : 0), 1'b0, 1'b0);
    end
    run_phase(0, 0, 240, 240, 0, 0, 240, 16, 60, 14, 14, 1'b0, 1'b0);

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
